FILE: rtl/sfrx_pkg.sv
// shared types and constants for the serial frame receiver with xor check
`timescale 1ns / 1ps

package sfrx_pkg;

    // operation codes carried on the input tuser
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_ARM  = 2'd2
    } op_t;

    // final status codes
    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_LOST     = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_START_BYTE    = 2'd0;
    localparam logic [1:0] REG_END_BYTE      = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0]  START_BYTE_RST    = 8'h02;
    localparam logic [7:0]  END_BYTE_RST      = 8'h03;
    localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd1019;

    // field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int MS_W   = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [MS_W-1:0] MS_MAX = 16'hFFFF;

endpackage

FILE: rtl/serial_frame_receiver_xor_check_top.sv
// serial frame receiver: start byte, 16-bit length, payload, xor checksum, end byte
`timescale 1ns / 1ps

//  channel | dir | tdata (low bit up)                             | tuser      | tlast
//  --------+-----+------------------------------------------------+------------+----------
//  s_      | in  | rx_byte[7:0], timeout_ms[23:8]                 | operation  | -
//  m_      | out | payload_byte[7:0], status[9:8],                | -          | frame_end
//          |     | payload_length[25:10], zero pad [31:26]        |            |
//  cfg_    | in  | write enable, register index, 16-bit write data|            |
//
//  one request accepted per cycle while the result side is not stalled; a result passes
//  through the input register, then the result register fed by the frame state update
//  aresetn is synchronous and active low; it clears the phase, counters and config
//  a stalled result holds the result register; the input register still takes a
//  request while it is empty or the result register is free or being drained this cycle

module serial_frame_receiver_xor_check_top (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // rx_byte[7:0], timeout_ms[23:8]
    input  logic [1:0]  s_tuser,    // operation[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // payload_byte[7:0], status[9:8], payload_length[25:10]
    output logic        m_tlast,    // frame_end
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    // receive phase: idle, payload, and one per header or trailer byte
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CHECK,
        PH_END
    } phase_t;

    // configuration
    logic [7:0]  start_byte_reg;
    logic [7:0]  end_byte_reg;
    logic [15:0] payload_limit_reg;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] in_tmo_reg;

    // frame state
    phase_t      phase_reg, phase_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0]  running_xor_reg, running_xor_next;
    logic [7:0]  received_xor_reg, received_xor_next;
    logic [15:0] elapsed_ms_reg, elapsed_ms_next;
    logic [15:0] deadline_ms_reg, deadline_ms_next;

    // result register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_last_reg;

    // combinational result of the request in the input register
    logic        res_valid;
    logic [7:0]  res_byte;
    logic        res_last;
    logic [1:0]  res_status;
    logic [15:0] res_len;

    logic        fire;
    logic [15:0] elapsed_inc;
    logic [15:0] seen_inc;
    logic [15:0] len_full;

    // the input register moves on whenever the result register can take its outcome
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // saturating millisecond count, payload count, full header length
    assign elapsed_inc = (elapsed_ms_reg == sfrx_pkg::MS_MAX) ? elapsed_ms_reg
                                                              : elapsed_ms_reg + 16'd1;
    assign seen_inc    = bytes_seen_reg + 16'd1;
    assign len_full    = {frame_length_reg[15:8], in_byte_reg};

    always_comb begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        bytes_seen_next   = bytes_seen_reg;
        running_xor_next  = running_xor_reg;
        received_xor_next = received_xor_reg;
        elapsed_ms_next   = elapsed_ms_reg;
        deadline_ms_next  = deadline_ms_reg;
        res_valid         = 1'b0;
        res_byte          = 8'h00;
        res_last          = 1'b0;
        res_status        = sfrx_pkg::ST_GOOD;
        res_len           = 16'd0;

        if (fire) begin
            case (in_op_reg)
                sfrx_pkg::OP_ARM: begin
                    // arming drops any open receive and starts over
                    phase_next        = PH_START;
                    frame_length_next = 16'd0;
                    bytes_seen_next   = 16'd0;
                    running_xor_next  = 8'h00;
                    received_xor_next = 8'h00;
                    elapsed_ms_next   = 16'd0;
                    deadline_ms_next  = in_tmo_reg;
                    if (in_tmo_reg == 16'd0) begin
                        // zero budget times out at once
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_last   = 1'b1;
                        res_status = sfrx_pkg::ST_TIMEOUT;
                    end
                end
                sfrx_pkg::OP_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        elapsed_ms_next = elapsed_inc;
                        if (elapsed_inc >= deadline_ms_reg) begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_last   = 1'b1;
                            res_status = sfrx_pkg::ST_TIMEOUT;
                            res_len    = frame_length_reg;
                        end
                    end
                end
                sfrx_pkg::OP_BYTE: begin
                    case (phase_reg)
                        PH_START: begin
                            if (in_byte_reg != start_byte_reg) begin
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res_last   = 1'b1;
                                res_status = sfrx_pkg::ST_LOST;
                                res_len    = frame_length_reg;
                            end else begin
                                phase_next = PH_LEN_HI;
                            end
                        end
                        PH_LEN_HI: begin
                            frame_length_next = {in_byte_reg, 8'h00};
                            running_xor_next  = running_xor_reg ^ in_byte_reg;
                            phase_next        = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            frame_length_next = len_full;
                            running_xor_next  = running_xor_reg ^ in_byte_reg;
                            if (len_full > payload_limit_reg) begin
                                // rest of the frame is not awaited
                                phase_next = PH_IDLE;
                                res_valid  = 1'b1;
                                res_last   = 1'b1;
                                res_status = sfrx_pkg::ST_TOO_LONG;
                                res_len    = len_full;
                            end else if (len_full == 16'd0) begin
                                phase_next = PH_CHECK;
                            end else begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD: begin
                            running_xor_next = running_xor_reg ^ in_byte_reg;
                            bytes_seen_next  = seen_inc;
                            if (seen_inc >= frame_length_reg) begin
                                phase_next = PH_CHECK;
                            end
                            res_valid = 1'b1;
                            res_byte  = in_byte_reg;
                        end
                        PH_CHECK: begin
                            received_xor_next = in_byte_reg;
                            phase_next        = PH_END;
                        end
                        PH_END: begin
                            // wrong end byte is tested before the checksum
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_last   = 1'b1;
                            res_len    = frame_length_reg;
                            if (in_byte_reg != end_byte_reg ||
                                running_xor_reg != received_xor_reg) begin
                                res_status = sfrx_pkg::ST_LOST;
                            end else begin
                                res_status = sfrx_pkg::ST_GOOD;
                            end
                        end
                        default: begin
                            // idle: byte dropped
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default: begin
                    // unused operation code, no effect
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg    <= sfrx_pkg::START_BYTE_RST;
            end_byte_reg      <= sfrx_pkg::END_BYTE_RST;
            payload_limit_reg <= sfrx_pkg::PAYLOAD_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sfrx_pkg::REG_START_BYTE:    start_byte_reg    <= cfg_wdata[7:0];
                sfrx_pkg::REG_END_BYTE:      end_byte_reg      <= cfg_wdata[7:0];
                sfrx_pkg::REG_PAYLOAD_LIMIT: payload_limit_reg <= cfg_wdata;
                default: begin
                    // unknown index ignored
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata[7:0];
            in_tmo_reg  <= s_tdata[23:8];
        end
    end

    // frame state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            frame_length_reg <= 16'd0;
            bytes_seen_reg   <= 16'd0;
            running_xor_reg  <= 8'h00;
            received_xor_reg <= 8'h00;
            elapsed_ms_reg   <= 16'd0;
            deadline_ms_reg  <= 16'd0;
            out_valid_reg    <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            bytes_seen_reg   <= bytes_seen_next;
            running_xor_reg  <= running_xor_next;
            received_xor_reg <= received_xor_next;
            elapsed_ms_reg   <= elapsed_ms_next;
            deadline_ms_reg  <= deadline_ms_next;
            if (fire) begin
                out_valid_reg <= res_valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            out_data_reg <= {6'b000000, res_len, res_status, res_byte};
            out_last_reg <= res_last;
        end
    end

endmodule

FILE: rtl/sfrx_checker.sv
// port-level checker for the serial frame receiver, bound to the top level
`timescale 1ns / 1ps

module sfrx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // payload byte results carry good status and zero length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[25:8] == 18'd0 &&
                                 m_tdata[9:8] == sfrx_pkg::ST_GOOD)
        else $error("payload result with status bits set");

    // status results carry a zero payload byte and zero padding
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00 && m_tdata[31:26] == 6'd0)
        else $error("status result with payload bits set");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind serial_frame_receiver_xor_check_top sfrx_checker u_sfrx_checker (.*);

FILE: tb/tb_serial_frame_receiver_xor_check_top.sv
// self-checking testbench for the serial frame receiver with xor check
`timescale 1ns / 1ps

module tb_serial_frame_receiver_xor_check_top;

    // run bounds
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int          STALL_CYCLES = 300;
    localparam int          SETTLE       = 8;     // pipeline is two deep, wait well past it
    localparam int          MAX_PRINTED  = 40;

    // unused operation code, the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // frame phases of the local copy of the receiver
    typedef enum logic [2:0] {
        RX_IDLE, RX_START, RX_LEN_HI, RX_LEN_LO, RX_PAYLOAD, RX_CHECK, RX_END
    } rx_phase_t;

    // shapes of stimulus sequences
    typedef enum int {
        FR_GOOD, FR_BAD_END, FR_BAD_SUM, FR_BAD_START,
        FR_TOO_LONG, FR_TIMEOUT, FR_ABORT, FR_NOISE
    } frame_kind_t;

    typedef struct {
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic [1:0]  status;
        logic [15:0] payload_length;
    } frame_result_t;

    // dut connections
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;     // rx_byte[7:0], timeout_ms[23:8]
    logic [1:0]  s_tuser;     // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;     // payload_byte[7:0], status[9:8], payload_length[25:10]
    logic        m_tlast;     // frame_end
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    // local copy of the configuration
    logic [7:0]  cfg_start = sfrx_pkg::START_BYTE_RST;
    logic [7:0]  cfg_end   = sfrx_pkg::END_BYTE_RST;
    logic [15:0] cfg_limit = sfrx_pkg::PAYLOAD_LIMIT_RST;

    // local copy of the frame state
    rx_phase_t   rx_phase      = RX_IDLE;
    logic [15:0] hdr_length    = '0;
    logic [15:0] payload_count = '0;
    logic [7:0]  xor_acc       = '0;
    logic [7:0]  xor_rcvd      = '0;
    logic [15:0] elapsed       = '0;
    logic [15:0] deadline      = '0;

    // results the block still owes, oldest first
    frame_result_t pending_results[$];

    int          error_count   = 0;
    int          live_items    = 0;    // accepted requests that the block acted on
    int          src_idle_pct  = 0;
    int          snk_idle_pct  = 0;
    int          hold_requests = 0;    // raised by the tests
    int          hold_served   = 0;    // followed by the ready process
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;

    serial_frame_receiver_xor_check_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // frame state predictor
    // ---------------------------------------------------------------

    // final status closes the receive
    function automatic void push_status(input logic [1:0] st);
        frame_result_t r;
        r.payload_byte   = '0;
        r.frame_end      = 1'b1;
        r.status         = st;
        r.payload_length = hdr_length;
        pending_results.push_back(r);
        rx_phase = RX_IDLE;
    endfunction

    function automatic void push_payload(input logic [7:0] b);
        frame_result_t r;
        r.payload_byte   = b;
        r.frame_end      = 1'b0;
        r.status         = '0;
        r.payload_length = '0;
        pending_results.push_back(r);
    endfunction

    // advance the local frame state by one accepted request
    task automatic predict_request(input logic [1:0] op, input logic [7:0] b,
                                   input logic [15:0] tmo, output bit ignored);
        ignored = 1'b0;
        if (op == sfrx_pkg::OP_ARM) begin
            // arming drops any open receive without a result
            rx_phase      = RX_START;
            hdr_length    = '0;
            payload_count = '0;
            xor_acc       = '0;
            xor_rcvd      = '0;
            elapsed       = '0;
            deadline      = tmo;
            if (tmo == 16'd0)
                push_status(sfrx_pkg::ST_TIMEOUT);
        end else if (rx_phase == RX_IDLE) begin
            ignored = 1'b1;
        end else if (op == sfrx_pkg::OP_TICK) begin
            if (elapsed != sfrx_pkg::MS_MAX)
                elapsed = elapsed + 16'd1;
            if (elapsed >= deadline)
                push_status(sfrx_pkg::ST_TIMEOUT);
        end else if (op == sfrx_pkg::OP_BYTE) begin
            case (rx_phase)
                RX_START: begin
                    if (b != cfg_start)
                        push_status(sfrx_pkg::ST_LOST);
                    else
                        rx_phase = RX_LEN_HI;
                end
                RX_LEN_HI: begin
                    hdr_length = {b, 8'h00};
                    xor_acc    = xor_acc ^ b;
                    rx_phase   = RX_LEN_LO;
                end
                RX_LEN_LO: begin
                    hdr_length = hdr_length | {8'h00, b};
                    xor_acc    = xor_acc ^ b;
                    if (hdr_length > cfg_limit)
                        push_status(sfrx_pkg::ST_TOO_LONG);
                    else
                        rx_phase = (hdr_length == 16'd0) ? RX_CHECK : RX_PAYLOAD;
                end
                RX_PAYLOAD: begin
                    xor_acc       = xor_acc ^ b;
                    payload_count = payload_count + 16'd1;
                    if (payload_count >= hdr_length)
                        rx_phase = RX_CHECK;
                    push_payload(b);
                end
                RX_CHECK: begin
                    xor_rcvd = b;
                    rx_phase = RX_END;
                end
                RX_END: begin
                    // end byte is judged before the checksum
                    if (b != cfg_end)
                        push_status(sfrx_pkg::ST_LOST);
                    else if (xor_acc != xor_rcvd)
                        push_status(sfrx_pkg::ST_LOST);
                    else
                        push_status(sfrx_pkg::ST_GOOD);
                end
                default: rx_phase = RX_IDLE;
            endcase
        end else begin
            ignored = 1'b1;
        end
    endtask

    // ---------------------------------------------------------------
    // result side: ready pattern and checking
    // ---------------------------------------------------------------

    // ready changes on the falling edge; a long hold-off is counted here
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_left   = STALL_CYCLES;
            hold_served = hold_requests;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // every accepted result against the oldest expectation
    always @(posedge aclk) begin : check_results
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, tdata low half", m_tdata[15:0], 16'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.payload_byte)
                    report_mismatch("payload_byte", 16'(m_tdata[7:0]),
                                    16'(want.payload_byte));
                if (m_tlast !== want.frame_end)
                    report_mismatch("frame_end", 16'(m_tlast), 16'(want.frame_end));
                if (m_tdata[9:8] !== want.status)
                    report_mismatch("status", 16'(m_tdata[9:8]), 16'(want.status));
                if (m_tdata[25:10] !== want.payload_length)
                    report_mismatch("payload_length", m_tdata[25:10], want.payload_length);
            end
        end
    end

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // one request, with random idle cycles ahead of it
    task automatic send_request(input logic [1:0] op, input logic [7:0] b,
                                input logic [15:0] tmo);
        bit ignored;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {tmo, b};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_request(op, b, tmo, ignored);
        if (!ignored)
            live_items++;
    endtask

    // a frame byte, now and then preceded by a millisecond tick
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(19) == 0)
            send_request(sfrx_pkg::OP_TICK, 8'($urandom), 16'($urandom));
        send_request(sfrx_pkg::OP_BYTE, b, 16'($urandom));
    endtask

    // sender pauses until the block owes nothing and has settled
    task automatic drain_block();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            sfrx_pkg::REG_START_BYTE:    cfg_start = val[7:0];
            sfrx_pkg::REG_END_BYTE:      cfg_end   = val[7:0];
            sfrx_pkg::REG_PAYLOAD_LIMIT: cfg_limit = val;
            default: ;
        endcase
    endtask

    // all three registers, only with the block drained
    task automatic apply_config(input logic [7:0] sb, input logic [7:0] eb,
                                input logic [15:0] lim);
        drain_block();
        write_register(sfrx_pkg::REG_START_BYTE, {8'h00, sb});
        write_register(sfrx_pkg::REG_END_BYTE, {8'h00, eb});
        write_register(sfrx_pkg::REG_PAYLOAD_LIMIT, lim);
    endtask

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 55) return FR_GOOD;
        if (r < 63) return FR_BAD_END;
        if (r < 71) return FR_BAD_SUM;
        if (r < 77) return FR_BAD_START;
        if (r < 83) return FR_TOO_LONG;
        if (r < 89) return FR_TIMEOUT;
        if (r < 94) return FR_ABORT;
        return FR_NOISE;
    endfunction

    function automatic logic [7:0] random_payload();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    // one arm plus a frame of the given shape with random content, or for noise one to six random requests
    task automatic send_frame(input frame_kind_t kind_in, input int max_len);
        frame_kind_t kind;
        int          cap;
        int          len;
        int          cut;
        int          tmo;
        logic [7:0]  sum;
        logic [7:0]  pl;
        logic [15:0] len_bits;
        kind = kind_in;
        if (kind == FR_TOO_LONG && cfg_limit == 16'hFFFF)
            kind = FR_GOOD;          // nothing can exceed the widest limit
        cap = (int'(cfg_limit) < max_len) ? int'(cfg_limit) : max_len;
        tmo = 1000 + $urandom_range(64535);

        if (kind == FR_NOISE) begin
            repeat ($urandom_range(6, 1))
                send_request(2'($urandom_range(3)), 8'($urandom), 16'($urandom));
        end else if (kind == FR_TIMEOUT) begin
            // short budget, header left hanging, ticks run it out
            tmo = $urandom_range(6, 1);
            send_request(sfrx_pkg::OP_ARM, 8'($urandom), 16'(tmo));
            send_request(sfrx_pkg::OP_BYTE, cfg_start, 16'($urandom));
            if ($urandom_range(1))
                send_request(sfrx_pkg::OP_BYTE, 8'($urandom), 16'($urandom));
            repeat (tmo)
                send_request(sfrx_pkg::OP_TICK, 8'($urandom), 16'($urandom));
        end else if (kind == FR_BAD_START) begin
            send_request(sfrx_pkg::OP_ARM, 8'($urandom), 16'(tmo));
            send_byte(cfg_start ^ 8'($urandom_range(255, 1)));
        end else if (kind == FR_TOO_LONG) begin
            len_bits = 16'($urandom_range(65535, int'(cfg_limit) + 1));
            send_request(sfrx_pkg::OP_ARM, 8'($urandom), 16'(tmo));
            send_byte(cfg_start);
            send_byte(len_bits[15:8]);
            send_byte(len_bits[7:0]);
        end else if (kind == FR_ABORT) begin
            // partial frame, the next arm drops it
            send_request(sfrx_pkg::OP_ARM, 8'($urandom), 16'(tmo));
            send_byte(cfg_start);
            if (cap >= 1) begin
                len      = $urandom_range(cap, 1);
                len_bits = 16'(len);
                send_byte(len_bits[15:8]);
                send_byte(len_bits[7:0]);
                cut = $urandom_range(len - 1, 0);
                repeat (cut)
                    send_byte(random_payload());
            end
        end else begin
            len      = $urandom_range(cap, 0);
            len_bits = 16'(len);
            send_request(sfrx_pkg::OP_ARM, 8'($urandom), 16'(tmo));
            send_byte(cfg_start);
            send_byte(len_bits[15:8]);
            send_byte(len_bits[7:0]);
            sum = len_bits[15:8] ^ len_bits[7:0];
            repeat (len) begin
                pl  = random_payload();
                sum = sum ^ pl;
                send_byte(pl);
            end
            if (kind == FR_BAD_SUM)
                sum = sum ^ 8'($urandom_range(255, 1));
            send_byte(sum);
            if (kind == FR_BAD_END)
                send_byte(cfg_end ^ 8'($urandom_range(255, 1)));
            else
                send_byte(cfg_end);
        end
    endtask

    // ---------------------------------------------------------------
    // directed tests, reset configuration
    // ---------------------------------------------------------------

    // bytes, ticks and the unused code with no receive open are dropped
    task automatic test_idle_requests();
        send_request(sfrx_pkg::OP_BYTE, 8'hFF, 16'hFFFF);
        send_request(sfrx_pkg::OP_TICK, 8'h00, 16'h0000);
        send_request(OP_UNUSED, 8'hA5, 16'h5A5A);
    endtask

    // zero budget times out as soon as it is armed
    task automatic test_zero_budget();
        send_request(sfrx_pkg::OP_ARM, 8'h00, 16'h0000);
    endtask

    // re-arm mid frame drops it, then a wrong start byte loses the frame
    task automatic test_rearm_bad_start();
        send_request(sfrx_pkg::OP_ARM, 8'h00, 16'd5);
        send_request(sfrx_pkg::OP_BYTE, cfg_start, 16'h0000);
        send_request(sfrx_pkg::OP_ARM, 8'hFF, 16'd50);
        send_request(sfrx_pkg::OP_BYTE, 8'h00, 16'hFFFF);
    endtask

    // widest length over the limit, flagged right after the header
    task automatic test_too_long();
        send_request(sfrx_pkg::OP_ARM, 8'h00, 16'hFFFF);
        send_request(sfrx_pkg::OP_BYTE, cfg_start, 16'h0000);
        send_request(sfrx_pkg::OP_BYTE, 8'hFF, 16'h0000);
        send_request(sfrx_pkg::OP_BYTE, 8'hFF, 16'h0000);
    endtask

    // empty payload with both checksum and end wrong
    task automatic test_empty_bad_end();
        send_request(sfrx_pkg::OP_ARM, 8'h00, 16'd4);
        send_request(sfrx_pkg::OP_BYTE, cfg_start, 16'h0000);
        send_request(sfrx_pkg::OP_BYTE, 8'h00, 16'h0000);
        send_request(sfrx_pkg::OP_BYTE, 8'h00, 16'h0000);
        send_request(sfrx_pkg::OP_BYTE, 8'h55, 16'h0000);
        send_request(sfrx_pkg::OP_BYTE, 8'hFF, 16'h0000);
    endtask

    // one payload byte passed out, then a checksum mismatch
    task automatic test_bad_checksum();
        send_request(sfrx_pkg::OP_ARM, 8'h00, 16'd3);
        send_request(sfrx_pkg::OP_BYTE, cfg_start, 16'h0000);
        send_request(sfrx_pkg::OP_BYTE, 8'h00, 16'h0000);
        send_request(sfrx_pkg::OP_BYTE, 8'h01, 16'h0000);
        send_request(sfrx_pkg::OP_BYTE, 8'hFF, 16'h0000);
        send_request(sfrx_pkg::OP_BYTE, 8'h00, 16'h0000);
        send_request(sfrx_pkg::OP_BYTE, cfg_end, 16'h0000);
    endtask

    // deadline reached by ticks
    task automatic test_tick_timeout();
        send_request(sfrx_pkg::OP_ARM, 8'h00, 16'd2);
        send_request(sfrx_pkg::OP_TICK, 8'hFF, 16'hFFFF);
        send_request(sfrx_pkg::OP_TICK, 8'h00, 16'h0000);
    endtask

    // ---------------------------------------------------------------
    // back-pressure and random traffic
    // ---------------------------------------------------------------

    // result side holds off while requests keep coming at full rate
    task automatic test_result_stall();
        drain_block();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_requests++;
        repeat (6)
            send_frame(FR_GOOD, 40);
        drain_block();
    endtask

    // random frames, a fresh configuration every hundred or so requests
    task automatic test_random_traffic(input int item_target, input int src_pct,
                                       input int snk_pct, input logic [7:0] sb,
                                       input logic [7:0] eb, input logic [15:0] lim);
        int          stop_at;
        int          seg_end;
        int          max_len;
        logic [7:0]  rnd_start;
        logic [7:0]  rnd_end;
        logic [15:0] rnd_limit;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        apply_config(sb, eb, lim);
        stop_at = live_items + item_target;
        while (live_items < stop_at) begin
            seg_end = live_items + 100;
            while (live_items < seg_end && live_items < stop_at) begin
                // mostly short payloads, now and then a longer one
                max_len = ($urandom_range(9) == 0) ? 40 : 8;
                send_frame(pick_kind(), max_len);
            end
            if (live_items < stop_at) begin
                rnd_start = 8'($urandom);
                rnd_end   = 8'($urandom);
                if ($urandom_range(3) == 0)
                    rnd_limit = 16'($urandom);
                else
                    rnd_limit = 16'($urandom_range(60));
                apply_config(rnd_start, rnd_end, rnd_limit);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // sequence of the run
    // ---------------------------------------------------------------

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = sfrx_pkg::OP_BYTE;
        cfg_wr_en = 1'b0;
        cfg_index = sfrx_pkg::REG_START_BYTE;
        cfg_wdata = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // directed part runs on the reset register values
        test_idle_requests();
        test_zero_budget();
        test_rearm_bad_start();
        test_too_long();
        test_empty_bad_end();
        test_bad_checksum();
        test_tick_timeout();

        test_result_stall();

        // three idle patterns, the first two opening on register extremes, the third on reset values
        test_random_traffic(350, 6, 83, 8'hFF, 8'h00, 16'h0000);
        test_random_traffic(350, 83, 6, 8'h00, 8'hFF, 16'hFFFF);
        test_random_traffic(350, 0, 0, sfrx_pkg::START_BYTE_RST, sfrx_pkg::END_BYTE_RST,
                            sfrx_pkg::PAYLOAD_LIMIT_RST);

        drain_block();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
